// File: sv/eta_phi_grid_accumulator_defines.svh
// Assertion macros shared by the eta-phi grid accumulator modules.
`ifndef ETA_PHI_GRID_ACCUMULATOR_DEFINES_SVH
`define ETA_PHI_GRID_ACCUMULATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define EPGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define EPGA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: sv/epga_pkg.sv
// Types, constants and codes of the eta-phi grid accumulator.
package epga_pkg;

  localparam int unsigned MaxEtaCellsDef  = 64;
  localparam int unsigned MaxPhiCellsDef  = 64;
  localparam int unsigned MaxConeStepsDef = 15;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  localparam logic [14:0] EtaMaxRst   = 15'd10240;
  localparam logic [6:0]  CellsRst    = 7'd64;
  localparam logic        PhiURangeRst = 1'b1;

  // 2*pi as a Q16 fraction, and ten times that for the phi step divisor
  localparam int unsigned TwoPiQ16 = 411775;
  localparam int unsigned SpDen    = 4117750;

  // Divider widths: dividend, divisor, quotient
  localparam int unsigned DivNW = 29;
  localparam int unsigned DivDW = 23;
  localparam int unsigned DivQW = 8;

  // Signed eta bin of the query center, with saturation marks
  localparam int unsigned QW = 10;
  localparam logic signed [QW-1:0] QSatPos = 10'sd256;
  localparam logic signed [QW-1:0] QSatNeg = -10'sd257;

  typedef enum logic [1:0] {
    MODE_DEPOSIT = 2'd0,
    MODE_CONE    = 2'd1,
    MODE_CLEAR   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ETA_MAX    = 2'd0,
    CFG_ETA_CELLS  = 2'd1,
    CFG_PHI_CELLS  = 2'd2,
    CFG_PHI_URANGE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_ETA = 2'd0,
    DIV_SE  = 2'd1
  } div_sel_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [23:0]        energy;
    logic signed [15:0] eta;
    logic [15:0]        phi;
    logic [14:0]        cone_radius;
  } epga_in_t;

  typedef struct packed {
    logic        accepted;
    logic [11:0] cell_index;
    logic [41:0] cone_energy;
  } epga_res_t;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     div_start;
    div_sel_e div_sel;
    logic     dep_rd;
    logic     dep_wr;
    logic     align_step;
    logic     scan_init;
    logic     scan_step;
    logic     drain;
    logic     clr_step;
  } epga_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       div_done;
    logic       align_zero;
    logic       scan_last;
    logic       clr_last;
  } epga_stat_t;

endpackage

// File: sv/eta_phi_grid_accumulator.sv
// Top level of the eta-phi energy grid accumulator.
// An item is taken when start is high and busy is low; its one result appears
// on res_o for exactly one cycle with done_o high and must be captured then,
// as the block cannot be held off. Timing is set by the shared bit-serial
// divider and the single grid read port: a deposit divides once, a cone
// query divides twice and then reads the (2*sp+1)*(2*se+1) cells of its
// window with se, sp the eta and phi step counts, a clear sweeps every grid
// cell and an unused mode goes straight to its result. After reset every
// one of the MAX_ETA_CELLS*MAX_PHI_CELLS grid cells (4096 by default) is
// swept to zero with busy high.
// Configuration writes are always ready and may be sent while idle.
module eta_phi_grid_accumulator import epga_pkg::*; #(
  parameter int unsigned MaxEtaCells  = MaxEtaCellsDef,
  parameter int unsigned MaxPhiCells  = MaxPhiCellsDef,
  parameter int unsigned MaxConeSteps = MaxConeStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  epga_in_t            in_i,
  output logic                done_o,
  output epga_res_t           res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  epga_cmd_t  cmd;
  epga_stat_t stat;

  assign cfg_ready_o = 1'b1;

  epga_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o
  );

  epga_datapath #(
    .MaxEtaCells  (MaxEtaCells),
    .MaxPhiCells  (MaxPhiCells),
    .MaxConeSteps (MaxConeSteps)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_i,
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o
  );

endmodule

// File: sv/epga_ram.sv
// Generic simple dual-port RAM with registered read.
module epga_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/epga_div.sv
// Restoring divider, one quotient bit per cycle, with overflow flag.
`include "eta_phi_grid_accumulator_defines.svh"
module epga_div import epga_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] dividend_i,
  input  logic [DivDW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivQW-1:0] quo_o,
  output logic [DivDW-1:0] rem_o,
  output logic             sat_o
);

  localparam int unsigned CW = $clog2(DivQW);
  localparam int unsigned SW = DivDW + DivQW - 1;

  logic             run_q, done_q, sat_q;
  logic [CW-1:0]    cnt_q;
  logic [DivNW-1:0] rem_q;
  logic [SW-1:0]    ds_q;
  logic [DivQW-1:0] quo_q;
  logic             ge;

  assign ge = {{(SW-DivNW){1'b0}}, rem_q} >= ds_q;

  // Control: run flag and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: subtract shifted divisor, shift in a quotient bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      ds_q  <= {divisor_i, {(DivQW-1){1'b0}}};
      sat_q <= {2'b00, dividend_i} >= {divisor_i, {DivQW{1'b0}}};
      cnt_q <= CW'(DivQW - 1);
      quo_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - ds_q[DivNW-1:0];
      end
      ds_q  <= ds_q >> 1;
      quo_q <= {quo_q[DivQW-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DivDW-1:0];
  assign sat_o  = sat_q;

  `EPGA_NEVER(a_no_restart, start_i && run_q, "divider restarted while running")

endmodule

// File: sv/epga_datapath.sv
// Datapath: config registers, binning, divider, grid memory and cone sum.
module epga_datapath import epga_pkg::*; #(
  parameter int unsigned MaxEtaCells  = MaxEtaCellsDef,
  parameter int unsigned MaxPhiCells  = MaxPhiCellsDef,
  parameter int unsigned MaxConeSteps = MaxConeStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  epga_in_t            in_i,
  input  epga_cmd_t           cmd_i,
  output epga_stat_t          stat_o,
  output epga_res_t           res_o
);

  localparam int unsigned Depth = MaxEtaCells * MaxPhiCells;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW    = (MaxPhiCells > 1) ? $clog2(MaxPhiCells) : 1;
  localparam int unsigned SW    = $clog2(MaxConeSteps + 1);
  localparam int unsigned KW    = SW + 1;
  localparam int unsigned EcCap = (MaxEtaCells > 127) ? 127 : MaxEtaCells;
  localparam int unsigned PcCap = (MaxPhiCells > 127) ? 127 : MaxPhiCells;

  // Configuration registers
  logic [14:0] eta_max_q;
  logic [6:0]  eta_cells_q, phi_cells_q;
  logic        phi_urange_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_max_q    <= EtaMaxRst;
      eta_cells_q  <= CellsRst;
      phi_cells_q  <= CellsRst;
      phi_urange_q <= PhiURangeRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ETA_MAX:    eta_max_q    <= cfg_data_i;
        CFG_ETA_CELLS:  eta_cells_q  <= cfg_data_i[6:0];
        CFG_PHI_CELLS:  phi_cells_q  <= cfg_data_i[6:0];
        CFG_PHI_URANGE: phi_urange_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective grid settings
  logic [14:0] em;
  logic [15:0] span;
  logic [6:0]  ec, pc, pc_m1;

  assign em    = (eta_max_q == '0) ? 15'd1 : eta_max_q;
  assign span  = {em, 1'b0};
  assign ec    = (eta_cells_q == '0) ? 7'd1 :
                 (eta_cells_q > 7'(EcCap)) ? 7'(EcCap) : eta_cells_q;
  assign pc    = (phi_cells_q == '0) ? 7'd1 :
                 (phi_cells_q > 7'(PcCap)) ? 7'(PcCap) : phi_cells_q;
  assign pc_m1 = pc - 7'd1;

  // Item registers and products
  epga_in_t           in_q;
  logic signed [23:0] base_q;
  logic [21:0]        rec_q, rpc_q;
  logic signed [17:0] eta_off;
  logic signed [25:0] base_full;
  logic [15:0]        pphi;
  logic [22:0]        pprod;

  assign eta_off   = $signed({{2{in_q.eta[15]}}, in_q.eta}) + $signed({3'b000, em});
  assign base_full = 26'($signed({1'b0, ec}) * eta_off);
  assign pphi      = in_q.phi ^ {~phi_urange_q, 15'b0};
  assign pprod     = 23'(pphi) * 23'(pc);

  // Divider operands
  logic [25:0]        ten_rec;
  logic signed [26:0] num_se;
  logic [19:0]        den_se;
  logic [28:0]        h_rpc;
  logic               pos_se;
  logic [DivNW-1:0]   div_n;
  logic [DivDW-1:0]   div_d;

  assign ten_rec = {1'b0, rec_q, 3'b000} + {3'b000, rec_q, 1'b0};
  assign num_se  = $signed({1'b0, ten_rec}) - $signed({11'b0, span});
  assign den_se  = {1'b0, em, 4'b0000} + {3'b000, em, 2'b00};
  assign h_rpc   = {rpc_q, 7'b0} + {2'b00, rpc_q, 5'b0};
  assign pos_se  = !num_se[26] && (num_se != '0);

  // Phi step count: count the divisor multiples that the numerator exceeds
  logic [SW-1:0] sp_c;

  always_comb begin
    sp_c = '0;
    for (int unsigned k = 0; k < MaxConeSteps; k++) begin
      if (h_rpc > 29'(TwoPiQ16 + k * SpDen)) sp_c = sp_c + SW'(1);
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SE: begin
        div_n = {3'b000, num_se[25:0]} + {9'b0, den_se} - 29'd1;
        div_d = {3'b000, den_se};
      end
      default: begin
        div_n = base_q[23] ? {5'b0, ~base_q} : {5'b0, base_q};
        div_d = {7'b0, span};
      end
    endcase
  end

  logic             div_done, div_sat;
  logic [DivQW-1:0] div_quo;
  logic [DivDW-1:0] div_rem;
  div_sel_e         div_sel_q;

  epga_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .sat_o      (div_sat)
  );

  // Window position logic
  logic signed [QW-1:0] q_q;
  logic                 remz_q;
  logic [SW-1:0]        se_q, sp_q, align_q, steps_c;
  logic signed [KW-1:0] ke_q;
  logic [KW-1:0]        kp_q;
  logic [PW-1:0]        pi_q;
  logic signed [QW-1:0] ee, n10;
  logic                 hit_c, pi_last, ke_last;
  logic [6:0]           bin7;
  logic [13:0]          prod14;
  logic [15:0]          idx16;

  assign n10     = $signed({3'b000, ec});
  assign ee      = q_q + $signed({{(QW-KW){ke_q[KW-1]}}, ke_q});
  assign hit_c   = !ee[QW-1] && ((ee < n10) || (ee == n10 && remz_q));
  assign bin7    = (ee >= n10) ? pc_m1 & 7'h00 | (ec - 7'd1) : ee[6:0];
  assign prod14  = 14'(bin7) * 14'(pc);
  assign idx16   = {2'b00, prod14} + 16'(pi_q);
  assign pi_last = (8'(pi_q) == {1'b0, pc_m1});
  assign ke_last = (ke_q == $signed({1'b0, se_q}));
  assign steps_c = (div_sat || div_quo > DivQW'(MaxConeSteps)) ?
                   SW'(MaxConeSteps) : SW'(div_quo);

  // Grid memory
  logic [AW-1:0] clr_q, addr_q;
  logic [11:0]   idx12_q;
  logic          hit_q, vld_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [32:0]   sum33;

  assign sum33     = {1'b0, ram_rdata} + {9'b0, in_q.energy};
  assign ram_we    = cmd_i.clr_step || (cmd_i.dep_wr && hit_q);
  assign ram_waddr = cmd_i.clr_step ? clr_q : addr_q;
  assign ram_wdata = cmd_i.clr_step ? 32'd0 :
                     (sum33[32] ? 32'hFFFF_FFFF : sum33[31:0]);

  epga_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.dep_rd || cmd_i.scan_step),
    .raddr_i (idx16[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Cone accumulator
  logic [41:0] acc_q, acc_add;
  epga_res_t   res_q;

  assign acc_add = vld_q ? {10'b0, ram_rdata} : 42'd0;

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.scan_step && hit_c;
      if (cmd_i.clr_step) begin
        clr_q <= (clr_q == AW'(Depth - 1)) ? '0 : clr_q + 1'b1;
      end
    end
  end

  // Item data, window walk and results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q  <= in_i;
      res_q <= '0;
    end
    if (cmd_i.prep) begin
      base_q <= base_full[23:0];
      rec_q  <= 22'(in_q.cone_radius) * 22'(ec);
      rpc_q  <= 22'(in_q.cone_radius) * 22'(pc);
      pi_q   <= PW'(pprod[22:16]);
      ke_q   <= '0;
    end
    if (cmd_i.div_start) begin
      div_sel_q <= cmd_i.div_sel;
    end
    if (div_done) begin
      case (div_sel_q)
        DIV_SE: begin
          se_q    <= pos_se ? steps_c : '0;
          sp_q    <= sp_c;
          align_q <= sp_c;
        end
        default: begin
          if (base_q[23]) begin
            q_q    <= div_sat ? QSatNeg : -$signed({2'b00, div_quo}) - QW'(1);
            remz_q <= (div_rem == {7'b0, span - 16'd1});
          end else begin
            q_q    <= div_sat ? QSatPos : $signed({2'b00, div_quo});
            remz_q <= (div_rem == '0);
          end
        end
      endcase
    end
    // step the center back to the first phi column
    if (cmd_i.align_step) begin
      pi_q    <= (pi_q == '0) ? PW'(pc_m1) : pi_q - 1'b1;
      align_q <= align_q - 1'b1;
    end
    if (cmd_i.scan_init) begin
      ke_q  <= -$signed({1'b0, se_q});
      kp_q  <= {sp_q, 1'b0};
      acc_q <= '0;
    end
    // advance eta inside a column, then wrap to the next phi column
    if (cmd_i.scan_step) begin
      if (ke_last) begin
        ke_q <= -$signed({1'b0, se_q});
        pi_q <= pi_last ? '0 : pi_q + 1'b1;
        kp_q <= kp_q - 1'b1;
      end else begin
        ke_q <= ke_q + KW'(1);
      end
    end
    if (cmd_i.scan_step || cmd_i.drain) begin
      acc_q <= acc_q + acc_add;
    end
    if (cmd_i.drain) begin
      res_q.cone_energy <= acc_q + acc_add;
    end
    if (cmd_i.dep_rd) begin
      addr_q  <= idx16[AW-1:0];
      idx12_q <= idx16[11:0];
      hit_q   <= hit_c;
    end
    if (cmd_i.dep_wr) begin
      res_q.accepted   <= hit_q;
      res_q.cell_index <= hit_q ? idx12_q : 12'd0;
    end
  end

  assign stat_o.mode       = in_q.mode;
  assign stat_o.div_done   = div_done;
  assign stat_o.align_zero = (align_q == '0);
  assign stat_o.scan_last  = ke_last && (kp_q == '0);
  assign stat_o.clr_last   = (clr_q == AW'(Depth - 1));
  assign res_o             = res_q;

endmodule

// File: sv/epga_ctrl.sv
// Controller state machine sequencing deposits, cone queries and clears.
`include "eta_phi_grid_accumulator_defines.svh"
module epga_ctrl import epga_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  epga_stat_t stat_i,
  output epga_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  typedef enum logic [13:0] {
    S_INIT     = 14'h0001,
    S_IDLE     = 14'h0002,
    S_PREP     = 14'h0004,
    S_CLEAR    = 14'h0008,
    S_ETA_GO   = 14'h0010,
    S_ETA_WAIT = 14'h0020,
    S_SE_GO    = 14'h0040,
    S_SE_WAIT  = 14'h0080,
    S_ALIGN    = 14'h0100,
    S_SCAN     = 14'h0200,
    S_DRAIN    = 14'h0400,
    S_DEP_RD   = 14'h0800,
    S_DEP_WR   = 14'h1000,
    S_DONE     = 14'h2000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        case (stat_i.mode)
          MODE_DEPOSIT, MODE_CONE: state_d = S_ETA_GO;
          MODE_CLEAR:              state_d = S_CLEAR;
          default:                 state_d = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_DONE;
      end
      S_ETA_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ETA;
        state_d         = S_ETA_WAIT;
      end
      S_ETA_WAIT: begin
        if (stat_i.div_done) begin
          state_d = (stat_i.mode == MODE_DEPOSIT) ? S_DEP_RD : S_SE_GO;
        end
      end
      S_SE_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SE;
        state_d         = S_SE_WAIT;
      end
      S_SE_WAIT: begin
        if (stat_i.div_done) state_d = S_ALIGN;
      end
      S_ALIGN: begin
        if (stat_i.align_zero) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end else begin
          cmd_o.align_step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = S_DONE;
      end
      S_DEP_RD: begin
        cmd_o.dep_rd = 1'b1;
        state_d      = S_DEP_WR;
      end
      S_DEP_WR: begin
        cmd_o.dep_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  `EPGA_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `EPGA_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted item did not raise busy")
  `EPGA_ASSERT(a_done_in_item, done_o |-> busy_o, "result strobe outside an item")

endmodule
